[design/m640_pkg.sv]
package m640_pkg;

    // Item codes carried in the func field.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_STEP   = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam int NUM_WORDS = 5;
    localparam int NUM_LANES = 4;
    localparam logic [3:0] LAST_HALF_INDEX = 4'd9;

    // Per-round lane rotation amounts and word rotation as a lane offset.
    localparam logic [4:0] LANE_ROT [NUM_WORDS] = '{5'd5, 5'd31, 5'd7, 5'd22, 5'd13};
    localparam logic [1:0] WORD_ROT_SRC [NUM_WORDS] = '{2'd3, 2'd2, 2'd1, 2'd2, 2'd3};

    // Word, then lane, then bit.
    typedef logic [NUM_WORDS-1:0][NUM_LANES-1:0][31:0] t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  word_index;
        logic [63:0] word_data;
    } t_in;

    typedef struct packed {
        logic [63:0] keystream_low;
        logic [63:0] keystream_high;
    } t_out;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

[design/morus640_keystream_step.sv]
// MORUS-640 state and keystream step. One beat enters per cycle when the
// result side keeps up: each item is held in the input register and is
// then applied to the state, with the update rounds computed combinationally;
// a step's keystream beat is registered in the output register as the step
// is applied. Loads write one 64-bit half of a state word, steps give the
// keystream and then run the five update rounds, update-only items run
// the rounds silently. The input side stalls only while a step waits for
// the output register to be taken.
module morus640_keystream_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  m640_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output m640_pkg::t_out  o_out
);
    import m640_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    t_state r_state;
    t_state n_state;
    t_state w_upd_state;
    logic   r_out_valid;
    t_out   r_out;
    logic   w_out_free;
    logic   w_is_step;
    logic   w_adv;
    logic [NUM_LANES-1:0][31:0] w_ks;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_step  = r_in.func == FUNC_STEP;
    assign w_adv      = r_in_valid && (!w_is_step || w_out_free);
    assign o_in_stall = r_in_valid && !w_adv;

    m640_update u_update (
        .i_state (r_state),
        .o_state (w_upd_state)
    );

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            w_ks[i] = r_state[0][i] ^ r_state[1][2'(i + 1)]
                    ^ (r_state[2][i] & r_state[3][i]);
        end
    end

    always_comb begin
        n_state = r_state;
        if (w_adv) begin
            case (r_in.func)
                FUNC_LOAD: begin
                    if (r_in.word_index <= LAST_HALF_INDEX) begin
                        n_state[r_in.word_index[3:1]][{r_in.word_index[0], 1'b0}] =
                            r_in.word_data[31:0];
                        n_state[r_in.word_index[3:1]][{r_in.word_index[0], 1'b1}] =
                            r_in.word_data[63:32];
                    end
                end
                FUNC_STEP, FUNC_UPDATE: n_state = w_upd_state;
                default: n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_state <= n_state;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_adv && w_is_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (w_adv && w_is_step) begin
            r_out.keystream_low  <= {w_ks[1], w_ks[0]};
            r_out.keystream_high <= {w_ks[3], w_ks[2]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_stall_only_for_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && w_is_step && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked step");

    a_step_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_is_step |=> o_out_valid)
        else $error("step did not produce an output beat");

    a_silent_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !w_is_step && w_out_free |=> !o_out_valid)
        else $error("load or update-only item produced an output beat");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("state changed without an item being applied");
`endif

endmodule

[design/m640_update.sv]
module m640_update (
    input  m640_pkg::t_state i_state,
    output m640_pkg::t_state o_state
);
    import m640_pkg::*;

    // Five rounds with a zero message; round j works on words j .. j+3 mod 5.
    always_comb begin
        t_state                     st;
        logic [NUM_LANES-1:0][31:0] moved;
        logic [2:0]                 a;
        logic [2:0]                 b;
        logic [2:0]                 c;
        logic [2:0]                 d;
        logic [1:0]                 ln;
        logic [1:0]                 src;
        st = i_state;
        for (int j = 0; j < NUM_WORDS; j++) begin
            a = 3'(j);
            b = 3'((j + 1) % NUM_WORDS);
            c = 3'((j + 2) % NUM_WORDS);
            d = 3'((j + 3) % NUM_WORDS);
            for (int i = 0; i < NUM_LANES; i++) begin
                ln = 2'(i);
                st[a][ln] = rotl32(st[a][ln] ^ st[d][ln] ^ (st[b][ln] & st[c][ln]),
                                   LANE_ROT[j]);
            end
            for (int i = 0; i < NUM_LANES; i++) begin
                ln  = 2'(i);
                src = ln + WORD_ROT_SRC[j];
                moved[ln] = st[d][src];
            end
            st[d] = moved;
        end
        o_state = st;
    end

endmodule
